>>> sv/idos_pkg.sv
`default_nettype none
package idos_pkg;
	localparam int SAMPLE_W = 12;
	localparam int MAX_W = 12;
	localparam int FLOOR_W = 13;
	localparam int NORM_W = 16;
	localparam int ERR_W = 17;
	localparam int LANES = 3;
	localparam int NORM_DIV_W = SAMPLE_W + 12;
	localparam int RATIO_DIV_W = NORM_W + 1 + 12;

	localparam logic [1:0] REG_LEFT_MAX = 2'd0;
	localparam logic [1:0] REG_MIDDLE_MAX = 2'd1;
	localparam logic [1:0] REG_RIGHT_MAX = 2'd2;
	localparam logic [1:0] REG_NORM_FLOOR = 2'd3;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

>>> sv/inductor_diff_over_sum_steering_error_unit.sv
`default_nettype none
// Steering error from three inductor readings.
// Input channel: in_valid/in_stall with left/middle/right_sample.
// Output channel: out_valid/out_stall with steer_error and the three norms.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Three lanes normalize the channels in parallel with one restoring divider
// each (one quotient bit per cycle); the merge stage then runs a restoring
// divide for (n0-n2)/(n0+n2). out_valid rises after the lane divides, the
// merge divide and the load into the output register.
// Lanes and merge overlap: the next word enters the lanes while the merge
// works, and the output register frees the merge while a result waits.
// When the receiver keeps up, throughput is set by the merge (start, 29
// steps, load into the output register).
// Reset clears the valid flags and loads the default calibration
// (max 4095, floor 4). If out_stall is high the result holds unchanged;
// the merge and lanes finish and hold their words, then in_stall rises.
module inductor_diff_over_sum_steering_error_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [11:0] left_sample,
	input  wire logic [11:0] middle_sample,
	input  wire logic [11:0] right_sample,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [16:0] steer_error,
	output logic [15:0] left_norm,
	output logic [15:0] middle_norm,
	output logic [15:0] right_norm,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [12:0] cfg_data
);
	logic [11:0] max_q [3];
	logic [12:0] floor_q;
	logic [11:0] samp [3];
	logic [15:0] norm [3];
	idos_pkg::div_ctl_t lane_ctl [3];
	idos_pkg::div_ctl_t mctl;
	logic [16:0] err;
	logic [15:0] nh_q [3];
	logic lanes_busy_q, merge_busy_q, held_q;
	logic accept, out_take, mstart, out_load;

	assign samp[0] = left_sample;
	assign samp[1] = middle_sample;
	assign samp[2] = right_sample;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q[0] <= 12'd4095;
			max_q[1] <= 12'd4095;
			max_q[2] <= 12'd4095;
			floor_q <= 13'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				idos_pkg::REG_LEFT_MAX: max_q[0] <= cfg_data[11:0];
				idos_pkg::REG_MIDDLE_MAX: max_q[1] <= cfg_data[11:0];
				idos_pkg::REG_RIGHT_MAX: max_q[2] <= cfg_data[11:0];
				idos_pkg::REG_NORM_FLOOR: floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a word when lanes free and merge can take their result later
	assign in_stall = lanes_busy_q || held_q;
	assign accept = in_valid && !in_stall;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		idos_norm_lane u_lane (
			.clk(clk), .arst_n(arst_n), .start(accept), .sample(samp[i]),
			.maxv(max_q[i]), .floor_v(floor_q), .ctl(lane_ctl[i]), .norm(norm[i])
		);
	end

	// Lanes finished: start merge if free, else hold norms
	assign mstart = (lane_ctl[0].done && !merge_busy_q) || (held_q && !merge_busy_q);
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (lane_ctl[0].done) begin
			nh_q[0] <= norm[0];
			nh_q[1] <= norm[1];
			nh_q[2] <= norm[2];
		end
	end

	logic [15:0] mn [3];
	assign mn[0] = held_q ? nh_q[0] : norm[0];
	assign mn[1] = held_q ? nh_q[1] : norm[1];
	assign mn[2] = held_q ? nh_q[2] : norm[2];

	idos_merge u_merge (
		.clk(clk), .arst_n(arst_n), .start(mstart), .n0(mn[0]), .n1(mn[1]),
		.n2(mn[2]), .ctl(mctl), .err(err)
	);

	logic [15:0] mnorm_q [3];
	always_ff @(posedge clk) begin
		if (mstart) begin
			mnorm_q[0] <= mn[0];
			mnorm_q[1] <= mn[1];
			mnorm_q[2] <= mn[2];
		end
	end

	// Move a finished merge result into the output register when it is free
	assign out_load = (mctl.done || (merge_busy_q && !mctl.busy)) && (!out_valid || out_take);

	// Track busy flags; merge busy until its result lands in output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_busy_q <= 1'b0;
			merge_busy_q <= 1'b0;
			held_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) lanes_busy_q <= 1'b1;
			else if (lane_ctl[0].done) lanes_busy_q <= 1'b0;
			if (lane_ctl[0].done && merge_busy_q) held_q <= 1'b1;
			else if (mstart) held_q <= 1'b0;
			if (out_load) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
			if (mstart) merge_busy_q <= 1'b1;
			else if (out_load) merge_busy_q <= 1'b0;
		end
	end

	// Load output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			steer_error <= err;
			left_norm <= mnorm_q[0];
			middle_norm <= mnorm_q[1];
			right_norm <= mnorm_q[2];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(steer_error))
		else $error("result changed under stall");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lanes_busy_q |-> in_stall)
		else $error("accept while lanes busy");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lane_ctl[0].done == lane_ctl[2].done)
		else $error("lanes out of step");
endmodule
`default_nettype wire

>>> sv/idos_norm_lane.sv
`default_nettype none
// One lane: restoring divide of sample*4096 by max, one quotient bit per cycle.
module idos_norm_lane (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [idos_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [idos_pkg::MAX_W-1:0] maxv,
	input  wire logic [idos_pkg::FLOOR_W-1:0] floor_v,
	output idos_pkg::div_ctl_t ctl,
	output logic [idos_pkg::NORM_W-1:0] norm
);
	localparam int DW = idos_pkg::NORM_DIV_W;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [idos_pkg::MAX_W:0] rem_q;
	logic [idos_pkg::MAX_W-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [idos_pkg::MAX_W+1:0] trial;
	logic [DW-1:0] quo_sat;

	assign trial = {rem_q, quo_q[DW-1]} - {2'b00, div_q};

	// Step one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {sample, 12'd0};
			rem_q <= '0;
			div_q <= maxv;
		end else if (busy_q) begin
			if (!trial[idos_pkg::MAX_W+1]) begin
				rem_q <= trial[idos_pkg::MAX_W:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[idos_pkg::MAX_W-1:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// Saturate, zero max, then floor
	always_comb begin
		if (div_q == '0 || quo_q[DW-1:idos_pkg::NORM_W] != '0) quo_sat = DW'(16'hFFFF);
		else quo_sat = quo_q;
		if (quo_sat <= DW'(floor_v)) norm = idos_pkg::NORM_W'(floor_v);
		else norm = quo_sat[idos_pkg::NORM_W-1:0];
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

>>> sv/idos_merge.sv
`default_nettype none
// Merge: signed diff over sum divide, add middle, halve, saturate.
module idos_merge (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [idos_pkg::NORM_W-1:0] n0,
	input  wire logic [idos_pkg::NORM_W-1:0] n1,
	input  wire logic [idos_pkg::NORM_W-1:0] n2,
	output idos_pkg::div_ctl_t ctl,
	output logic [idos_pkg::ERR_W-1:0] err
);
	localparam int DW = idos_pkg::RATIO_DIV_W;
	localparam int SW = idos_pkg::NORM_W + 1;
	localparam int CW = $clog2(DW + 1);
	localparam int NW1 = idos_pkg::NORM_W;

	logic [DW-1:0] quo_q;
	logic [SW:0] rem_q;
	logic [SW-1:0] sum_q;
	logic neg_q, busy_q, done_q;
	logic [NW1-1:0] n1_q;
	logic [CW-1:0] cnt_q;
	logic [SW+1:0] trial;
	logic signed [DW+1:0] total;
	logic signed [DW+1:0] half;
	logic [SW-1:0] diff;

	assign diff = (n0 >= n2) ? SW'(n0) - SW'(n2) : SW'(n2) - SW'(n0);
	assign trial = {rem_q, quo_q[DW-1]} - {2'b00, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {diff, 12'd0};
			rem_q <= '0;
			sum_q <= SW'(n0) + SW'(n2);
			neg_q <= n0 < n2;
			n1_q <= n1;
		end else if (busy_q) begin
			if (!trial[SW+1]) begin
				rem_q <= trial[SW:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SW-1:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// Zero sum gives ratio zero; halve with floor and clamp
	always_comb begin
		if (sum_q == '0) total = (DW+2)'(signed'({1'b0, n1_q}));
		else if (neg_q) total = (DW+2)'(n1_q) - (DW+2)'(quo_q);
		else total = (DW+2)'(n1_q) + (DW+2)'(quo_q);
		half = total >>> 1;
		if (half > 65535) err = 17'h0FFFF;
		else if (half < -65536) err = 17'h10000;
		else err = half[idos_pkg::ERR_W-1:0];
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule
`default_nettype wire
